// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file cwe_checker of the RTL folder.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cwe_pkg.sv =====
// Types, constants and the rounding helper of the contour wall extruder.
// Used by cwe_norm, contour_wall_extruder and cwe_checker.
package cwe_pkg;

  localparam int COORD_W  = 32;
  localparam int NRM_W    = 18;
  localparam int VEC_W    = 34;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 136;

  localparam logic [CFG_IDX_W-1:0] REG_Z_BOTTOM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_UPPER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SCALE = 2'd3;

  localparam logic signed [31:0] Z_BOTTOM_RST   = 32'sd0;
  localparam logic signed [31:0] Z_UPPER_RST    = 32'sd65536;
  localparam logic [31:0]        UNIT_SCALE_RST = 32'd4295;

  localparam logic [17:0]        NRM_ONE   = 18'd65536;
  localparam logic signed [36:0] DOT_LIMIT = 37'sd2147483648;
  localparam logic [2:0]         MIN_EMIT_PTS = 3'd4;
  localparam logic [2:0]         CNT_SAT = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pnt_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] x;
  } nvec_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] ax;
    logic signed [VEC_W-1:0] ay;
  } norm_req_t;

  typedef struct packed {
    logic  done;
    nvec_t n;
  } norm_rsp_t;

  // Round a Q.16-scaled product to nearest (ties up) and saturate to 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd32768) >>> 16;
    if (t > 66'sd2147483647)
      return 32'sh7FFFFFFF;
    else if (t < -66'sd2147483648)
      return 32'sh80000000;
    else
      return t[31:0];
  endfunction

endpackage

// ===== hw/rtl/cwe_norm.sv =====
// Iterative vector normalizer: align shift, sum of squares, bit-serial square
// root and two restoring divisions, one step per cycle. Depends on cwe_pkg.
module cwe_norm (
  input  logic              clk,
  input  logic              rst,
  input  cwe_pkg::norm_req_t req,
  output cwe_pkg::norm_rsp_t rsp
);
  import cwe_pkg::*;

  typedef enum logic [2:0] {N_IDLE, N_ALIGN, N_SQA, N_SQB, N_ROOT, N_DSET, N_DIV} nst_t;

  nst_t        state;
  logic        negx, negy, phase;
  logic [32:0] ux, uy;
  logic [63:0] acc, root, rbit;
  logic [31:0] len, rem;
  logic [47:0] num;
  logic [17:0] q;
  logic [4:0]  qi;

  logic [32:0] m;
  logic [63:0] trial, root_next;
  logic        root_take;
  logic [17:0] num_lo;
  logic [32:0] rtry;
  logic        ge;
  logic [17:0] qf, qc;
  logic [30:0] mag;
  logic [47:0] num_init;

  always_comb begin
    m = (ux > uy) ? ux : uy;
    trial = root + rbit;
    root_take = (acc >= trial);
    root_next = root_take ? ((root >> 1) + rbit) : (root >> 1);
    num_lo = num[17:0];
    rtry = {rem, num_lo[qi]};
    ge = (rtry >= {1'b0, len});
    qf = {q[16:0], ge};
    qc = (qf > NRM_ONE) ? NRM_ONE : qf;
    mag = phase ? uy[30:0] : ux[30:0];
    num_init = {1'b0, mag, 16'd0} + {17'd0, len[31:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      rsp.done <= 1'b0;
    end else begin
      // A zero vector answers at once; otherwise the y division ends the work.
      rsp.done <= ((state == N_IDLE) && req.start && req.ax == '0 && req.ay == '0) ||
                  ((state == N_DIV) && qi == 5'd0 && phase);
      unique case (state)
        N_IDLE: begin
          if (req.start) begin
            negx <= req.ax < 0;
            negy <= req.ay < 0;
            ux <= (req.ax < 0) ? 33'(-req.ax) : 33'(req.ax);
            uy <= (req.ay < 0) ? 33'(-req.ay) : 33'(req.ay);
            phase <= 1'b0;
            if (req.ax == '0 && req.ay == '0) begin
              rsp.n <= '0;
            end else begin
              state <= N_ALIGN;
            end
          end
        end
        N_ALIGN: begin
          // Bring the larger magnitude into [2^30, 2^31).
          if (m[32] || m[31]) begin
            ux <= ux >> 1;
            uy <= uy >> 1;
          end else if (!m[30]) begin
            ux <= ux << 1;
            uy <= uy << 1;
          end else begin
            state <= N_SQA;
          end
        end
        N_SQA: begin
          acc <= 64'(ux[30:0]) * 64'(ux[30:0]);
          state <= N_SQB;
        end
        N_SQB: begin
          acc <= acc + 64'(uy[30:0]) * 64'(uy[30:0]);
          root <= '0;
          rbit <= 64'd1 << 62;
          state <= N_ROOT;
        end
        N_ROOT: begin
          if (root_take)
            acc <= acc - trial;
          root <= root_next;
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            len <= root_next[31:0];
            state <= N_DSET;
          end
        end
        N_DSET: begin
          num <= num_init;
          rem <= {2'd0, num_init[47:18]};
          q <= '0;
          qi <= 5'd17;
          state <= N_DIV;
        end
        N_DIV: begin
          rem <= ge ? 32'(rtry - {1'b0, len}) : rtry[31:0];
          q <= qf;
          qi <= qi - 5'd1;
          if (qi == 5'd0) begin
            if (!phase) begin
              rsp.n.x <= negx ? -$signed(qc) : $signed(qc);
              phase <= 1'b1;
              state <= N_DSET;
            end else begin
              rsp.n.y <= negy ? -$signed(qc) : $signed(qc);
              state <= N_IDLE;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/contour_wall_extruder.sv =====
// Contour wall extruder: takes outline points one at a time and emits the
// wall triangles of each closed contour. A point that needs no normalization
// passes MULX, MULY, RNDY, PUSH and AFTER before ready returns; a contour
// that closes also runs its tail segments. A segment needs up to two uses of
// the shared normalizer plus six vertex transactions. One point is in work
// at a time.
// Synchronous active-high reset: registers back to defaults, contour emptied.
module contour_wall_extruder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cwe_pkg::S_DATA_W-1:0]    s_tdata,   // point_x, point_y
  input  logic                            s_tlast,   // end_of_contour
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cwe_pkg::M_DATA_W-1:0]    m_tdata,   // vertex_x, vertex_y, vertex_z, normal_x, normal_y
  output logic                            m_tlast,   // last_of_run
  input  logic                            cfg_we,
  input  logic [cwe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import cwe_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE, T_MULX, T_MULY, T_RNDY, T_PUSH, T_SIDE_WAIT, T_UPD, T_AFTER, T_TAIL,
    T_DOT_A, T_DOT_B, T_BLEND, T_BLEND_WAIT, T_EMIT
  } tst_t;

  typedef enum logic [1:0] {RET_UPD, RET_TAIL4, RET_DONE} ret_t;

  tst_t  state;
  ret_t  seg_ret;

  logic signed [31:0] z_bottom, z_upper;
  logic               invert_faces;
  logic [31:0]        unit_scale;

  logic signed [31:0] in_x, in_y;
  logic               in_end, closing;
  logic signed [65:0] prod;
  logic signed [31:0] cur_xr;
  pnt_t  cur, first_v, second_v, rv0, rv1;
  nvec_t fn0, fn1, rn0, rn1, new_n;
  logic [2:0] pcount;

  pnt_t  seg_p0, seg_p1;
  nvec_t seg_prev, seg_own, seg_next, seg_n0, seg_n1;
  logic  seg_last, sel;
  logic signed [36:0] dot;
  logic [2:0] vidx;

  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  nvec_t other, side;
  pnt_t  vp;
  nvec_t vn;
  logic signed [31:0] vz, ztop, zbot;

  cwe_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (norm_req),
    .rsp (norm_rsp)
  );

  always_comb begin
    other = sel ? seg_next : seg_prev;
    if (invert_faces) begin
      side.x = norm_rsp.n.y;
      side.y = -norm_rsp.n.x;
    end else begin
      side.x = -norm_rsp.n.y;
      side.y = norm_rsp.n.x;
    end
    ztop = invert_faces ? z_bottom : z_upper;
    zbot = invert_faces ? z_upper : z_bottom;
    case (vidx) inside
      3'd0, 3'd5: begin vp = seg_p0; vz = ztop; vn = seg_n0; end
      3'd4:       begin vp = seg_p0; vz = zbot; vn = seg_n0; end
      3'd1:       begin vp = seg_p1; vz = ztop; vn = seg_n1; end
      default:    begin vp = seg_p1; vz = zbot; vn = seg_n1; end
    endcase
  end

  assign s_tready = (state == T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      z_bottom <= Z_BOTTOM_RST;
      z_upper <= Z_UPPER_RST;
      invert_faces <= 1'b0;
      unit_scale <= UNIT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_Z_BOTTOM:   z_bottom <= cfg_data;
        REG_Z_UPPER:    z_upper <= cfg_data;
        REG_INVERT:     invert_faces <= cfg_data[0];
        REG_UNIT_SCALE: unit_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      pcount <= '0;
      m_tvalid <= 1'b0;
      norm_req.start <= 1'b0;
    end else begin
      // The normalizer starts for a new side normal or for a blend.
      norm_req.start <= ((state == T_PUSH) && pcount != '0 && cur != rv1) ||
                        ((state == T_BLEND) && dot > DOT_LIMIT);
      // A vertex is offered whenever the emitter runs; it only waits while stalled.
      if (state == T_EMIT)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            in_x <= s_tdata[31:0];
            in_y <= s_tdata[63:32];
            in_end <= s_tlast;
            closing <= 1'b0;
            state <= T_MULX;
          end
        end
        T_MULX: begin
          prod <= 66'(in_x) * 66'($signed({1'b0, unit_scale}));
          state <= T_MULY;
        end
        T_MULY: begin
          cur_xr <= round_sat(prod);
          prod <= 66'(in_y) * 66'($signed({1'b0, unit_scale}));
          state <= T_RNDY;
        end
        T_RNDY: begin
          cur.x <= cur_xr;
          cur.y <= round_sat(-prod);
          state <= T_PUSH;
        end
        T_PUSH: begin
          if (pcount == '0) begin
            first_v <= cur;
            rv1 <= cur;
            pcount <= 3'd1;
            state <= T_AFTER;
          end else if (cur == rv1) begin
            state <= T_AFTER;
          end else begin
            norm_req.ax <= 34'(cur.x) - 34'(rv1.x);
            norm_req.ay <= 34'(cur.y) - 34'(rv1.y);
            state <= T_SIDE_WAIT;
          end
        end
        T_SIDE_WAIT: begin
          if (norm_rsp.done) begin
            new_n <= side;
            if (pcount >= 3'd3) begin
              seg_p0 <= rv0;
              seg_p1 <= rv1;
              seg_prev <= rn0;
              seg_own <= rn1;
              seg_next <= side;
              // Only an ordinary point without end of contour ends the run here.
              seg_last <= !closing && !in_end;
              seg_ret <= RET_UPD;
              sel <= 1'b0;
              state <= T_DOT_A;
            end else begin
              state <= T_UPD;
            end
          end
        end
        T_UPD: begin
          if (pcount == 3'd1) begin
            second_v <= cur;
            fn0 <= new_n;
          end
          if (pcount == 3'd2)
            fn1 <= new_n;
          rv0 <= rv1;
          rv1 <= cur;
          rn0 <= rn1;
          rn1 <= new_n;
          if (pcount != CNT_SAT)
            pcount <= pcount + 3'd1;
          state <= T_AFTER;
        end
        T_AFTER: begin
          if (closing) begin
            state <= T_TAIL;
          end else if (in_end) begin
            if (pcount != '0 && rv1 != first_v) begin
              cur <= first_v;
              closing <= 1'b1;
              state <= T_PUSH;
            end else begin
              state <= T_TAIL;
            end
          end else begin
            state <= T_IDLE;
          end
        end
        T_TAIL: begin
          if (pcount >= MIN_EMIT_PTS) begin
            seg_p0 <= rv0;
            seg_p1 <= rv1;
            seg_prev <= rn0;
            seg_own <= rn1;
            seg_next <= fn0;
            seg_last <= 1'b0;
            seg_ret <= RET_TAIL4;
            sel <= 1'b0;
            state <= T_DOT_A;
          end else begin
            pcount <= '0;
            state <= T_IDLE;
          end
        end
        T_DOT_A: begin
          dot <= 37'(seg_own.x) * 37'(other.x);
          state <= T_DOT_B;
        end
        T_DOT_B: begin
          dot <= dot + 37'(seg_own.y) * 37'(other.y);
          state <= T_BLEND;
        end
        T_BLEND: begin
          if (dot > DOT_LIMIT) begin
            norm_req.ax <= 34'(seg_own.x) + 34'(other.x);
            norm_req.ay <= 34'(seg_own.y) + 34'(other.y);
            state <= T_BLEND_WAIT;
          end else begin
            if (sel) begin
              seg_n1 <= seg_own;
              vidx <= '0;
              state <= T_EMIT;
            end else begin
              seg_n0 <= seg_own;
              sel <= 1'b1;
              state <= T_DOT_A;
            end
          end
        end
        T_BLEND_WAIT: begin
          if (norm_rsp.done) begin
            if (sel) begin
              seg_n1 <= norm_rsp.n;
              vidx <= '0;
              state <= T_EMIT;
            end else begin
              seg_n0 <= norm_rsp.n;
              sel <= 1'b1;
              state <= T_DOT_A;
            end
          end
        end
        T_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {4'd0, vn.y, vn.x, vz, vp.y, vp.x};
            m_tlast <= (vidx == 3'd5) && seg_last;
            vidx <= vidx + 3'd1;
            if (vidx == 3'd5) begin
              unique case (seg_ret)
                RET_UPD: state <= T_UPD;
                RET_TAIL4: begin
                  // Segment 0 closes the contour's output.
                  seg_p0 <= first_v;
                  seg_p1 <= second_v;
                  seg_prev <= rn1;
                  seg_own <= fn0;
                  seg_next <= fn1;
                  seg_last <= 1'b1;
                  seg_ret <= RET_DONE;
                  sel <= 1'b0;
                  state <= T_DOT_A;
                end
                RET_DONE: begin
                  pcount <= '0;
                  state <= T_IDLE;
                end
                default: state <= T_IDLE;
              endcase
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cwe_checker.sv =====
// Port-level checker for contour_wall_extruder, bound to the top level.
// Depends on cwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cwe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [cwe_pkg::M_DATA_W-1:0] m_tdata
);
  import cwe_pkg::*;

  // A point is worked on before the next one is taken.
  `CWE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

  `CWE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled vertex changed")

  `CWE_ASSERT_NOW(a_nx_range, m_tvalid, ($signed(m_tdata[113:96]) <= 18'sd65536) && ($signed(m_tdata[113:96]) >= -18'sd65536), "normal_x out of range")

  `CWE_ASSERT_NOW(a_ny_range, m_tvalid, ($signed(m_tdata[131:114]) <= 18'sd65536) && ($signed(m_tdata[131:114]) >= -18'sd65536), "normal_y out of range")

endmodule

bind contour_wall_extruder cwe_checker u_cwe_checker (.*);
